/* sv/mbe_pkg.sv */
// Shared widths and format constants for the Mandelbrot escape-time unit.
package mbe_pkg;

    // Point coordinates arrive as signed Q4.28 words
    localparam int C_IN_W    = 32;
    localparam int C_IN_FRAC = 28;

    // Iteration limit register and escape count width
    localparam int CNT_W = 16;

    // Iteration limit after reset
    localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd255;

    typedef logic [CNT_W-1:0] count_t;

endpackage

/* sv/mandelbrot_escape_time.sv */
// Top level of the Mandelbrot escape-time unit with a bit-serial complex squarer.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  point     | point_valid / point_ready  | c_real, c_imag (signed Q4.28)
//  result    | result_valid / result_ready| escape_count (16 b), escaped (1 b)
//  cfg       | cfg_valid / cfg_ready      | max_iterations (16 b)
//
// Each iteration runs the large-component test, then the shift-and-add multipliers over
// the FRAC_BITS+2 magnitude bits (one magnitude bit per cycle), then the sum test and
// the add of c.
// Reset sets the limit to 255; no memory, so no clearing pass is needed.
// A finished result waits in the output register while the next point is accepted;
// the following result holds in the finish state until that register is free.
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     point_valid,
    output logic                     point_ready,
    input  logic signed [C_IN_W-1:0] c_real,
    input  logic signed [C_IN_W-1:0] c_imag,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [CNT_W-1:0]         escape_count,
    output logic                     escaped,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CNT_W-1:0]         max_iterations
);

    // z width, magnitude width, product width, square width, cross term width
    localparam int ZW   = FRAC_BITS + 6;
    localparam int MW   = FRAC_BITS + 2;
    localparam int PW   = 2 * MW;
    localparam int SW   = PW - FRAC_BITS;
    localparam int QW   = PW - FRAC_BITS + 1;
    localparam int BC_W = $clog2(MW);

    localparam logic signed [ZW-1:0] TWO_Z     = ZW'(2) <<< FRAC_BITS;
    localparam logic signed [ZW-1:0] NEG_TWO_Z = -TWO_Z;
    localparam logic [SW:0]          FOUR_S    = (SW+1)'(4) << FRAC_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    // control registers
    logic [2:0]  state_reg, state_next;
    logic        result_valid_reg, result_valid_next;
    count_t      max_iter_reg, max_iter_next;

    // datapath registers
    logic signed [ZW-1:0] zr_reg, zr_next;
    logic signed [ZW-1:0] zi_reg, zi_next;
    logic signed [ZW-1:0] cr_reg, cr_next;
    logic signed [ZW-1:0] ci_reg, ci_next;
    logic signed [ZW-1:0] diff_reg, diff_next;
    logic signed [ZW-1:0] cross_reg, cross_next;
    logic [MW-1:0]        ar_reg, ar_next;
    logic [MW-1:0]        ai_reg, ai_next;
    logic [MW-1:0]        mr_reg, mr_next;
    logic [MW-1:0]        mi_reg, mi_next;
    logic [PW-1:0]        p_rr_reg, p_rr_next;
    logic [PW-1:0]        p_ri_reg, p_ri_next;
    logic [PW-1:0]        p_ii_reg, p_ii_next;
    logic                 xneg_reg, xneg_next;
    logic [BC_W-1:0]      bit_cnt_reg, bit_cnt_next;
    count_t               idx_reg, idx_next;
    count_t               fin_count_reg, fin_count_next;
    logic                 fin_esc_reg, fin_esc_next;
    count_t               escape_count_reg, escape_count_next;
    logic                 escaped_reg, escaped_next;

    // combinational helpers
    logic signed [ZW-1:0] cr_scaled, ci_scaled;
    logic signed [ZW-1:0] zr_abs, zi_abs;
    logic                 big_comp;
    logic [MW:0]          rr_add, ri_add, ii_add;
    logic [SW-1:0]        sr, si;
    logic [SW:0]          mag_sum;
    logic [QW-1:0]        q_cross;
    logic                 rem_cross;
    logic signed [ZW-1:0] q_ext;
    logic                 out_free;

    // rescale c from Q4.28 to the working fraction width
    generate
        if (FRAC_BITS >= C_IN_FRAC) begin : g_c_up
            assign cr_scaled = ZW'(c_real) <<< (FRAC_BITS - C_IN_FRAC);
            assign ci_scaled = ZW'(c_imag) <<< (FRAC_BITS - C_IN_FRAC);
        end
        else begin : g_c_down
            assign cr_scaled = ZW'(c_real >>> (C_IN_FRAC - FRAC_BITS));
            assign ci_scaled = ZW'(c_imag >>> (C_IN_FRAC - FRAC_BITS));
        end
    endgenerate

    // magnitudes and the large-component test
    assign zr_abs   = zr_reg[ZW-1] ? -zr_reg : zr_reg;
    assign zi_abs   = zi_reg[ZW-1] ? -zi_reg : zi_reg;
    assign big_comp = (zr_reg > TWO_Z) || (zr_reg < NEG_TWO_Z) ||
                      (zi_reg > TWO_Z) || (zi_reg < NEG_TWO_Z);

    // one shift-and-add step of each multiplier
    assign rr_add = {1'b0, p_rr_reg[PW-1:MW]} + (mr_reg[0] ? {1'b0, ar_reg} : '0);
    assign ri_add = {1'b0, p_ri_reg[PW-1:MW]} + (mr_reg[0] ? {1'b0, ai_reg} : '0);
    assign ii_add = {1'b0, p_ii_reg[PW-1:MW]} + (mi_reg[0] ? {1'b0, ai_reg} : '0);

    // truncated squares, escape sum and floored doubled cross product
    assign sr        = p_rr_reg[PW-1:FRAC_BITS];
    assign si        = p_ii_reg[PW-1:FRAC_BITS];
    assign mag_sum   = {1'b0, sr} + {1'b0, si};
    assign q_cross   = p_ri_reg[PW-1:FRAC_BITS-1];
    assign rem_cross = |p_ri_reg[FRAC_BITS-2:0];
    assign q_ext     = ZW'(q_cross);

    assign out_free = !result_valid_reg || result_ready;

    // sequencer and datapath next values
    always_comb
    begin
        state_next        = state_reg;
        max_iter_next     = max_iter_reg;
        result_valid_next = result_valid_reg && !result_ready;
        zr_next           = zr_reg;
        zi_next           = zi_reg;
        cr_next           = cr_reg;
        ci_next           = ci_reg;
        diff_next         = diff_reg;
        cross_next        = cross_reg;
        ar_next           = ar_reg;
        ai_next           = ai_reg;
        mr_next           = mr_reg;
        mi_next           = mi_reg;
        p_rr_next         = p_rr_reg;
        p_ri_next         = p_ri_reg;
        p_ii_next         = p_ii_reg;
        xneg_next         = xneg_reg;
        bit_cnt_next      = bit_cnt_reg;
        idx_next          = idx_reg;
        fin_count_next    = fin_count_reg;
        fin_esc_next      = fin_esc_reg;
        escape_count_next = escape_count_reg;
        escaped_next      = escaped_reg;

        if (cfg_valid)
        begin
            max_iter_next = max_iterations;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    cr_next    = cr_scaled;
                    ci_next    = ci_scaled;
                    zr_next    = '0;
                    zi_next    = '0;
                    idx_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (big_comp)
                begin
                    fin_count_next = idx_reg;
                    fin_esc_next   = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    ar_next      = zr_abs[MW-1:0];
                    ai_next      = zi_abs[MW-1:0];
                    mr_next      = zr_abs[MW-1:0];
                    mi_next      = zi_abs[MW-1:0];
                    xneg_next    = zr_reg[ZW-1] ^ zi_reg[ZW-1];
                    p_rr_next    = '0;
                    p_ri_next    = '0;
                    p_ii_next    = '0;
                    bit_cnt_next = '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                p_rr_next    = {rr_add, p_rr_reg[MW-1:1]};
                p_ri_next    = {ri_add, p_ri_reg[MW-1:1]};
                p_ii_next    = {ii_add, p_ii_reg[MW-1:1]};
                mr_next      = {1'b0, mr_reg[MW-1:1]};
                mi_next      = {1'b0, mi_reg[MW-1:1]};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BC_W'(MW - 1))
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (mag_sum > FOUR_S)
                begin
                    fin_count_next = idx_reg;
                    fin_esc_next   = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    diff_next  = ZW'(sr) - ZW'(si);
                    cross_next = xneg_reg ? -(q_ext + ZW'(rem_cross)) : q_ext;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                zr_next = diff_reg + cr_reg;
                zi_next = cross_reg + ci_reg;
                if (idx_reg == max_iter_reg)
                begin
                    fin_count_next = '0;
                    fin_esc_next   = 1'b0;
                    state_next     = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_FIN:
            begin
                // hold the result until the output register is free
                if (out_free)
                begin
                    escape_count_next = fin_count_reg;
                    escaped_next      = fin_esc_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            max_iter_reg     <= MAX_ITER_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            max_iter_reg     <= max_iter_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        zr_reg           <= zr_next;
        zi_reg           <= zi_next;
        cr_reg           <= cr_next;
        ci_reg           <= ci_next;
        diff_reg         <= diff_next;
        cross_reg        <= cross_next;
        ar_reg           <= ar_next;
        ai_reg           <= ai_next;
        mr_reg           <= mr_next;
        mi_reg           <= mi_next;
        p_rr_reg         <= p_rr_next;
        p_ri_reg         <= p_ri_next;
        p_ii_reg         <= p_ii_next;
        xneg_reg         <= xneg_next;
        bit_cnt_reg      <= bit_cnt_next;
        idx_reg          <= idx_next;
        fin_count_reg    <= fin_count_next;
        fin_esc_reg      <= fin_esc_next;
        escape_count_reg <= escape_count_next;
        escaped_reg      <= escaped_next;
    end

    assign point_ready  = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign escape_count = escape_count_reg;
    assign escaped      = escaped_reg;

endmodule

/* sv/mbe_checker.sv */
// Port-level checks for the Mandelbrot escape-time unit, bound to its top level.
module mbe_checker
    import mbe_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     point_valid,
    input logic                     point_ready,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic [CNT_W-1:0]         escape_count,
    input logic                     escaped,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input logic [CNT_W-1:0]         max_iterations
);

    logic [1:0] pending_reg, pending_next;
    count_t     lim_reg, lim_next;
    logic       pt_beat, res_beat;

    assign pt_beat  = point_valid && point_ready;
    assign res_beat = result_valid && result_ready;

    // track points in flight and the limit last written
    always_comb
    begin
        pending_next = pending_reg + 2'(pt_beat) - 2'(res_beat);
        lim_next     = (cfg_valid && cfg_ready) ? max_iterations : lim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            lim_reg     <= MAX_ITER_RESET;
        end
        else
        begin
            pending_reg <= pending_next;
            lim_reg     <= lim_next;
        end
    end

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(escape_count) && $stable(escaped))
        else $error("result beat changed while stalled");

    // no result without a point in flight, and at most one point waiting behind it
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid |-> pending_reg != 2'd0) and (pt_beat |-> pending_reg <= 2'd1))
        else $error("result and point beats out of balance");

    // a point inside the set reports a zero count
    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !escaped |-> escape_count == '0)
        else $error("nonzero count for a point inside the set");

    // the escape index never passes the limit, and a zero limit never escapes
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && escaped |-> escape_count <= lim_reg && lim_reg != '0)
        else $error("escape count outside the iteration limit");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the Mandelbrot escape-time unit.
`timescale 1ns / 100ps

module testbench;
    import mbe_pkg::*;

    // Q4.28 and Q6.28 scaling
    localparam int     FRAC        = 28;
    localparam int     ONE_Q       = 1 << FRAC;
    localparam longint TWO_Z       = longint'(2) << FRAC;
    localparam longint FOUR_Z      = longint'(4) << FRAC;
    localparam int     HOLD_CYCLES = 2000;
    localparam int     TAIL_CYCLES = 1000;
    localparam int     PHASES      = 12;
    localparam int     PHASE_ITEMS = 110;

    typedef struct packed {
        logic signed [C_IN_W-1:0] re;
        logic signed [C_IN_W-1:0] im;
    } point_t;

    typedef struct packed {
        count_t escape_count;
        logic   escaped;
    } escape_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     point_valid   = 1'b0;
    logic                     point_ready;
    logic signed [C_IN_W-1:0] c_real        = '0;
    logic signed [C_IN_W-1:0] c_imag        = '0;
    logic                     result_valid;
    logic                     result_ready  = 1'b0;
    logic [CNT_W-1:0]         escape_count;
    logic                     escaped;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_limit     = '0;

    point_t  pending_points[$];
    escape_t expected_escapes[$];
    count_t  limit_now    = MAX_ITER_RESET;
    bit      point_fire   = 1'b0;
    bit      hold_armed   = 1'b0;
    int      hold_count   = 0;
    int      idle_pct     = 33;
    int      fail_count   = 0;
    int      points_taken = 0;
    int      escaped_seen = 0;
    int      inside_seen  = 0;
    int      input_stalls = 0;
    int      limit_writes = 0;

    mandelbrot_escape_time dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_valid),
        .point_ready   (point_ready),
        .c_real        (c_real),
        .c_imag        (c_imag),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .escape_count  (escape_count),
        .escaped       (escaped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .max_iterations(cfg_limit)
    );

    always #1 clk = ~clk;

    // Iterate z <- z*z + c from zero and report the first index where |z|^2 > 4
    function automatic escape_t escape_time_of(input logic signed [C_IN_W-1:0] re_in,
                                               input logic signed [C_IN_W-1:0] im_in,
                                               input count_t limit);
        longint  cr;
        longint  ci;
        longint  zr;
        longint  zi;
        longint  sr;
        longint  si;
        longint  zr_next;
        int      k;
        escape_t r;
        cr = re_in;
        ci = im_in;
        zr = 0;
        zi = 0;
        r.escape_count = '0;
        r.escaped = 1'b0;
        for (k = 0; k <= int'(limit); k++) begin
            // a component beyond two escapes without multiplying
            if (zr > TWO_Z || zr < -TWO_Z || zi > TWO_Z || zi < -TWO_Z) begin
                r.escape_count = count_t'(k);
                r.escaped = 1'b1;
                return r;
            end
            sr = (zr * zr) >>> FRAC;
            si = (zi * zi) >>> FRAC;
            if (sr + si > FOUR_Z) begin
                r.escape_count = count_t'(k);
                r.escaped = 1'b1;
                return r;
            end
            zr_next = sr - si + cr;
            zi = ((zr * zi) >>> (FRAC - 1)) + ci;
            zr = zr_next;
        end
        return r;
    endfunction

    // Mostly points near the set, some tiny ones, some anywhere in Q4.28
    function automatic point_t random_point();
        int     pick;
        point_t p;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            p.re = int'($urandom_range(0, 805306368)) - 603979776;
            p.im = int'($urandom_range(0, 671088640)) - 335544320;
        end else if (pick < 85) begin
            p.re = int'($urandom_range(0, 2097152)) - 1048576;
            p.im = int'($urandom_range(0, 2097152)) - 1048576;
        end else begin
            p.re = $urandom;
            p.im = $urandom;
        end
        return p;
    endfunction

    // Points with one component beyond two, so they escape at index one
    function automatic point_t far_point();
        point_t p;
        int     mag;
        mag = int'($urandom_range(536870913, 2147483647));
        if ($urandom_range(0, 1) == 1)
            mag = -mag;
        if ($urandom_range(0, 1) == 1) begin
            p.re = mag;
            p.im = $urandom;
        end else begin
            p.re = $urandom;
            p.im = mag;
        end
        return p;
    endfunction

    task automatic add_point(input int re, input int im);
        point_t p;
        p.re = re;
        p.im = im;
        pending_points.push_back(p);
    endtask

    // Wait until every point is sent and every result has come back
    task automatic settle();
        while (pending_points.size() != 0 || point_valid || expected_escapes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input count_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_now = value;
        limit_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer the next point once the current beat is taken
    always @(negedge clk) begin
        point_t next_point;
        if (!point_valid || point_fire) begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_point = pending_points.pop_front();
                point_valid <= 1'b1;
                c_real <= next_point.re;
                c_imag <= next_point.im;
            end else begin
                point_valid <= 1'b0;
            end
        end
    end

    // Hold results back for a long stretch once armed
    always @(posedge clk) begin
        if (hold_armed && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    always @(negedge clk) begin
        if (hold_armed && hold_count < HOLD_CYCLES)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Check result beats, then predict for accepted point beats
    always @(posedge clk) begin
        escape_t want;
        if (rst_n && result_valid && result_ready) begin
            if (expected_escapes.size() == 0) begin
                $error("unexpected result: escape_count=%0d escaped=%0b",
                       escape_count, escaped);
                fail_count++;
            end else begin
                want = expected_escapes.pop_front();
                if (escape_count !== want.escape_count) begin
                    $error("escape_count: expected %0d, actual %0d",
                           want.escape_count, escape_count);
                    fail_count++;
                end
                if (escaped !== want.escaped) begin
                    $error("escaped: expected %0b, actual %0b", want.escaped, escaped);
                    fail_count++;
                end
                if (want.escaped)
                    escaped_seen++;
                else
                    inside_seen++;
            end
        end
        if (rst_n && point_valid && !point_ready && hold_armed && hold_count < HOLD_CYCLES)
            input_stalls++;
        point_fire = rst_n && point_valid && point_ready;
        if (point_fire) begin
            expected_escapes.push_back(escape_time_of(c_real, c_imag, limit_now));
            points_taken++;
        end
    end

    initial begin
        count_t phase_limit [PHASES];
        int     i;
        int     ph;
        phase_limit = '{16'd1, 16'd20, 16'd7, 16'd14, 16'd3, 16'd11,
                        16'd18, 16'd5, 16'd9, 16'd16, 16'd2, 16'd13};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed points at the reset limit
        add_point(0, 0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 0);
        add_point(0, 32'h8000_0000);
        add_point(-2 * ONE_Q, 0);
        add_point(2 * ONE_Q, 0);
        add_point(ONE_Q / 4, 0);
        add_point(ONE_Q / 4 + ONE_Q / 100, 0);
        add_point(0, ONE_Q);
        add_point(0, -ONE_Q);
        add_point(-ONE_Q, 0);
        add_point(1, -1);
        add_point(-1, 1);
        add_point(-3 * ONE_Q / 4, ONE_Q / 10);
        add_point(3 * ONE_Q / 10, ONE_Q / 2);
        settle();

        // Zero limit: nothing escapes
        write_limit(16'd0);
        for (i = 0; i < 30; i++)
            pending_points.push_back(random_point());
        settle();

        // Widest limit, only with points that escape by index two
        write_limit(16'hFFFF);
        add_point(2 * ONE_Q, 0);
        add_point(32'h8000_0000, 32'h8000_0000);
        for (i = 0; i < 40; i++)
            pending_points.push_back(far_point());
        settle();

        write_limit(MAX_ITER_RESET);
        for (i = 0; i < 20; i++)
            pending_points.push_back(random_point());
        settle();

        // Random phases at short limits
        for (ph = 0; ph < PHASES; ph++) begin
            write_limit(phase_limit[ph]);
            idle_pct = (ph == 3) ? 0 : 33;
            if (ph == 4)
                hold_armed = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) == 0)
                    pending_points.push_back(far_point());
                else
                    pending_points.push_back(random_point());
            end
            settle();
        end
        idle_pct = 33;

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d points over %0d limit writes: %0d escaped, %0d held inside",
                 points_taken, limit_writes, escaped_seen, inside_seen);
        $display("input held off for %0d cycles while results were blocked", input_stalls);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Guard against a hung run
    initial begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
